// ===== hw/rtl/bpmr_pkg.sv =====
// ----------------------------------------------------------------------------
// bpmr_pkg
// Shared types and constants for the bad pixel mean replacement block.
// ----------------------------------------------------------------------------
package bpmr_pkg;

  localparam int MAX_ROWS_DEF   = 256;
  localparam int MAX_COLS_DEF   = 256;
  localparam int PIXEL_BITS_DEF = 16;
  localparam int MAX_RADIUS_DEF = 7;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_READ    = 2'd1,
    MODE_CORRECT = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_ROWS    = 2'd0,
    CFG_FRAME_COLS    = 2'd1,
    CFG_KERNEL_RADIUS = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_out;
    logic        replaced;
    logic        coord_error;
  } out_item_t;

  // divider handshake
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== hw/rtl/bpmr_div.sv =====
// ----------------------------------------------------------------------------
// bpmr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpmr_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bpmr_pkg::div_ctl_t            ctl,
  input  logic [NUM_W-1:0]              num,
  input  logic [DEN_W-1:0]              den,
  output bpmr_pkg::div_sts_t            sts,
  output logic [NUM_W-1:0]              quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;

  // one shift-subtract step
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
    if (ctl.start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = quo_r;

endmodule

// ===== hw/rtl/bad_pixel_mean_replacement_core.sv =====
// ----------------------------------------------------------------------------
// bad_pixel_mean_replacement_core
// Frame store with neighbor-mean correction of defective pixels.
// ----------------------------------------------------------------------------
// Flow: a write goes straight to the result; a read passes ST_BAD first.
// Correct: ST_BAD, then a scan of the N clipped window pixels (up to 225, one
//   memory read a cycle), then a 24-bit serial divide when a mean is written back.
// One request at a time; the next is taken once the result has been accepted.
// Reset: synchronous, active low; config registers return to 256x256, radius 1.
//   The frame memory is not cleared; pixels are undefined until written.
module bad_pixel_mean_replacement_core #(
  parameter int MAX_ROWS   = bpmr_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = bpmr_pkg::MAX_COLS_DEF,
  parameter int PIXEL_BITS = bpmr_pkg::PIXEL_BITS_DEF,
  parameter int MAX_RADIUS = bpmr_pkg::MAX_RADIUS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bpmr_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bpmr_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [bpmr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [8:0]           cfg_data
);

  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int WIN_N  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CNT_W  = $clog2(WIN_N + 1);
  localparam int SUM_W  = PIXEL_BITS + CNT_W;
  localparam int WC_W   = 13; // window coordinate, 0..255+7 fits 13

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_BAD   = 7'b0000010,
    ST_SCAN  = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_WB    = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [8:0] rows_r, cols_r;
  logic [2:0] rad_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 9'd256;
      cols_r <= 9'd256;
      rad_r  <= 3'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        bpmr_pkg::CFG_FRAME_ROWS:    rows_r <= cfg_data;
        bpmr_pkg::CFG_FRAME_COLS:    cols_r <= cfg_data;
        bpmr_pkg::CFG_KERNEL_RADIUS: rad_r  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end
  assign cfg_ready = 1'b1;

  // effective sizes (saturated)
  logic [WC_W-1:0] eff_rows, eff_cols, eff_rad;
  assign eff_rows = (WC_W'(rows_r) > WC_W'(MAX_ROWS)) ? WC_W'(MAX_ROWS) : WC_W'(rows_r);
  assign eff_cols = (WC_W'(cols_r) > WC_W'(MAX_COLS)) ? WC_W'(MAX_COLS) : WC_W'(cols_r);
  assign eff_rad  = (WC_W'(rad_r) > WC_W'(MAX_RADIUS)) ? WC_W'(MAX_RADIUS) : WC_W'(rad_r);

  // frame memory: one write, one registered read
  logic [PIXEL_BITS-1:0] mem [DEPTH];
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [PIXEL_BITS-1:0] mem_wdata, mem_rdata_r;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= mem[mem_raddr];
  end

  // request registers
  logic [1:0]            mode_r;
  logic [WC_W-1:0]       prow_r, pcol_r;
  logic [PIXEL_BITS-1:0] bad_r, bad_nxt;
  logic [WC_W-1:0]       r1_r, c0_r, c1_r, x_r, y_r, x_nxt, y_nxt;
  logic [WC_W-1:0]       r0_n, c0_n, r1_n, c1_n;
  logic                  rd_v_r, rd_v_nxt;
  logic                  scan_end;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [15:0]           opix_r, opix_nxt;
  logic                  orep_r, orep_nxt, oerr_r, oerr_nxt;
  logic                  in_acc, coord_bad;
  logic [WC_W-1:0]       in_row, in_col;
  bpmr_pkg::div_ctl_t    div_ctl;
  bpmr_pkg::div_sts_t    div_sts;
  logic [SUM_W-1:0]      div_quo;

  assign in_ready = state_r == ST_IDLE;
  assign in_acc   = in_valid && in_ready;
  assign in_row   = WC_W'(in_data.row);
  assign in_col   = WC_W'(in_data.col);
  assign coord_bad = (in_row >= eff_rows) || (in_col >= eff_cols);

  // window bounds from the incoming coordinate
  assign r0_n = (in_row > eff_rad) ? in_row - eff_rad : '0;
  assign c0_n = (in_col > eff_rad) ? in_col - eff_rad : '0;
  assign r1_n = (in_row + eff_rad < eff_rows) ? in_row + eff_rad : eff_rows - 1'b1;
  assign c1_n = (in_col + eff_rad < eff_cols) ? in_col + eff_rad : eff_cols - 1'b1;

  assign scan_end = (x_r == r1_r) && (y_r == c1_r);

  function automatic logic [ADDR_W-1:0] addr_of(input logic [WC_W-1:0] r,
                                                  input logic [WC_W-1:0] c);
    addr_of = {r[ROW_W-1:0], c[COL_W-1:0]};
  endfunction

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    rd_v_nxt  = 1'b0;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    bad_nxt   = bad_r;
    opix_nxt  = opix_r;
    orep_nxt  = orep_r;
    oerr_nxt  = oerr_r;
    mem_we    = 1'b0;
    mem_waddr = addr_of(prow_r, pcol_r);
    mem_wdata = div_quo[PIXEL_BITS-1:0];
    mem_raddr = addr_of(x_r, y_r);
    div_ctl.start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        mem_raddr = addr_of(in_row, in_col);
        if (in_acc) begin
          opix_nxt = '0;
          orep_nxt = 1'b0;
          oerr_nxt = 1'b0;
          x_nxt    = r0_n;
          y_nxt    = c0_n;
          sum_nxt  = '0;
          cnt_nxt  = '0;
          if (in_data.mode == bpmr_pkg::MODE_NONE) begin
            state_nxt = ST_OUT;
          end else if (coord_bad) begin
            oerr_nxt  = 1'b1;
            state_nxt = ST_OUT;
          end else if (in_data.mode == bpmr_pkg::MODE_WRITE) begin
            mem_we    = 1'b1;
            mem_waddr = addr_of(in_row, in_col);
            mem_wdata = in_data.pixel_in[PIXEL_BITS-1:0];
            opix_nxt  = 16'(in_data.pixel_in[PIXEL_BITS-1:0]);
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_BAD;
          end
        end
      end
      ST_BAD: begin
        // read data of the addressed pixel arrives now
        bad_nxt  = mem_rdata_r;
        opix_nxt = 16'(mem_rdata_r);
        if (mode_r == bpmr_pkg::MODE_READ) begin
          state_nxt = ST_OUT;
        end else begin
          rd_v_nxt  = 1'b1;
          state_nxt = scan_end ? ST_DRAIN : ST_SCAN;
          if (!scan_end) begin
            if (y_r == c1_r) begin
              y_nxt = c0_r;
              x_nxt = x_r + 1'b1;
            end else begin
              y_nxt = y_r + 1'b1;
            end
          end
        end
      end
      ST_SCAN, ST_DRAIN: begin
        if (rd_v_r && mem_rdata_r != bad_r && mem_rdata_r != '0) begin
          sum_nxt = sum_r + SUM_W'(mem_rdata_r);
          cnt_nxt = cnt_r + 1'b1;
        end
        if (state_r == ST_SCAN) begin
          rd_v_nxt = 1'b1;
          if (scan_end) begin
            state_nxt = ST_DRAIN;
          end else if (y_r == c1_r) begin
            y_nxt = c0_r;
            x_nxt = x_r + 1'b1;
          end else begin
            y_nxt = y_r + 1'b1;
          end
        end else if (!rd_v_r) begin
          if (cnt_r == '0) begin
            state_nxt = ST_OUT;
          end else begin
            div_ctl.start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_sts.done) state_nxt = ST_WB;
      end
      ST_WB: begin
        mem_we    = 1'b1;
        opix_nxt  = 16'(div_quo[PIXEL_BITS-1:0]);
        orep_nxt  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_data.mode;
      prow_r <= in_row;
      pcol_r <= in_col;
      r1_r   <= r1_n;
      c0_r   <= c0_n;
      c1_r   <= c1_n;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    bad_r  <= bad_nxt;
    sum_r  <= sum_nxt;
    cnt_r  <= cnt_nxt;
    opix_r <= opix_nxt;
    orep_r <= orep_nxt;
    oerr_r <= oerr_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= rd_v_nxt;
    end
  end

  bpmr_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (div_ctl),
    .num  (sum_r),
    .den  (cnt_r),
    .sts  (div_sts),
    .quo  (div_quo)
  );

  assign out_valid          = state_r == ST_OUT;
  assign out_data.pixel_out = opix_r;
  assign out_data.replaced  = orep_r;
  assign out_data.coord_error = oerr_r;

  // checks
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("result and request overlap");
  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == ST_DIV) else $error("stray divider done");
  a_rep_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.replaced && out_data.coord_error))
    else $error("replaced with coordinate error");
  a_wb_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WB |-> $past(div_sts.done)) else $error("write back early");

endmodule
